// ----- sv/qsm_pkg.sv -----
// shared widths, constants and types for the quaternion-scale to matrix pipeline
// no dependencies
package qsm_pkg;

    localparam int Q_W       = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 34;
    localparam int SCL_W     = 50;
    localparam int ENT_W     = 24;
    localparam int TR_W      = 32;
    localparam int N_PROD    = 9;
    localparam int N_ENT     = 9;
    localparam int N_ROW     = 3;
    localparam int RND_SHIFT = 22;

    localparam logic signed [SUM_W-1:0] ONE_Q28   = 34'sd268435456;
    localparam logic signed [SCL_W:0]   RND_BIAS  = 51'sd2097152;
    localparam logic signed [SCL_W:0]   SAT_MAX   = 51'sd8388607;
    localparam logic signed [SCL_W:0]   SAT_MIN   = -51'sd8388608;
    localparam logic signed [ENT_W-1:0] ENT_MAX   = 24'sh7fffff;
    localparam logic signed [ENT_W-1:0] ENT_MIN   = 24'sh800000;

    // product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    typedef struct packed {
        logic signed [TR_W-1:0] x;
        logic signed [TR_W-1:0] y;
        logic signed [TR_W-1:0] z;
    } t_trans;

    typedef struct packed {
        t_trans                trans;
        logic signed [Q_W-1:0] sx;
        logic signed [Q_W-1:0] sy;
        logic signed [Q_W-1:0] sz;
    } t_side;

endpackage

// ----- sv/qsm_prod.sv -----
// stage 1: the nine quaternion component products, registered
// depends on qsm_pkg
module qsm_prod (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [qsm_pkg::Q_W-1:0]       i_quat_x,
    input  logic signed [qsm_pkg::Q_W-1:0]       i_quat_y,
    input  logic signed [qsm_pkg::Q_W-1:0]       i_quat_z,
    input  logic signed [qsm_pkg::Q_W-1:0]       i_quat_w,
    input  qsm_pkg::t_side                       i_side,
    output logic                                 o_valid,
    output logic signed [qsm_pkg::PROD_W-1:0]    o_prod [qsm_pkg::N_PROD],
    output qsm_pkg::t_side                       o_side
);

    logic                              r_valid;
    logic signed [qsm_pkg::PROD_W-1:0] n_prod [qsm_pkg::N_PROD];
    logic signed [qsm_pkg::PROD_W-1:0] r_prod [qsm_pkg::N_PROD];
    qsm_pkg::t_side                    r_side;

    always_comb begin
        n_prod[qsm_pkg::P_XX] = qsm_pkg::PROD_W'(i_quat_x) * qsm_pkg::PROD_W'(i_quat_x);
        n_prod[qsm_pkg::P_YY] = qsm_pkg::PROD_W'(i_quat_y) * qsm_pkg::PROD_W'(i_quat_y);
        n_prod[qsm_pkg::P_ZZ] = qsm_pkg::PROD_W'(i_quat_z) * qsm_pkg::PROD_W'(i_quat_z);
        n_prod[qsm_pkg::P_XY] = qsm_pkg::PROD_W'(i_quat_x) * qsm_pkg::PROD_W'(i_quat_y);
        n_prod[qsm_pkg::P_XZ] = qsm_pkg::PROD_W'(i_quat_x) * qsm_pkg::PROD_W'(i_quat_z);
        n_prod[qsm_pkg::P_YZ] = qsm_pkg::PROD_W'(i_quat_y) * qsm_pkg::PROD_W'(i_quat_z);
        n_prod[qsm_pkg::P_WX] = qsm_pkg::PROD_W'(i_quat_w) * qsm_pkg::PROD_W'(i_quat_x);
        n_prod[qsm_pkg::P_WY] = qsm_pkg::PROD_W'(i_quat_w) * qsm_pkg::PROD_W'(i_quat_y);
        n_prod[qsm_pkg::P_WZ] = qsm_pkg::PROD_W'(i_quat_w) * qsm_pkg::PROD_W'(i_quat_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_side  = r_side;

endmodule

// ----- sv/qsm_sum.sv -----
// stage 2: doubled product sums forming the unscaled rotation entries
// depends on qsm_pkg
module qsm_sum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [qsm_pkg::PROD_W-1:0]    i_prod [qsm_pkg::N_PROD],
    input  qsm_pkg::t_side                       i_side,
    output logic                                 o_valid,
    output logic signed [qsm_pkg::SUM_W-1:0]     o_ent [qsm_pkg::N_ENT],
    output qsm_pkg::t_side                       o_side
);

    logic                             r_valid;
    logic signed [qsm_pkg::SUM_W-1:0] n_ent [qsm_pkg::N_ENT];
    logic signed [qsm_pkg::SUM_W-1:0] r_ent [qsm_pkg::N_ENT];
    qsm_pkg::t_side                   r_side;

    // 2*(a + b) or 2*(a - b)
    function automatic logic signed [qsm_pkg::SUM_W-1:0] dbl(
        input logic signed [qsm_pkg::PROD_W-1:0] a,
        input logic signed [qsm_pkg::PROD_W-1:0] b,
        input logic                              sub
    );
        logic signed [qsm_pkg::SUM_W-1:0] s;
        if (sub) begin
            s = qsm_pkg::SUM_W'(a) - qsm_pkg::SUM_W'(b);
        end else begin
            s = qsm_pkg::SUM_W'(a) + qsm_pkg::SUM_W'(b);
        end
        return s <<< 1;
    endfunction

    always_comb begin
        n_ent[0] = qsm_pkg::ONE_Q28
                 - dbl(i_prod[qsm_pkg::P_YY], i_prod[qsm_pkg::P_ZZ], 1'b0);
        n_ent[1] = dbl(i_prod[qsm_pkg::P_XY], i_prod[qsm_pkg::P_WZ], 1'b0);
        n_ent[2] = dbl(i_prod[qsm_pkg::P_XZ], i_prod[qsm_pkg::P_WY], 1'b1);
        n_ent[3] = dbl(i_prod[qsm_pkg::P_XY], i_prod[qsm_pkg::P_WZ], 1'b1);
        n_ent[4] = qsm_pkg::ONE_Q28
                 - dbl(i_prod[qsm_pkg::P_XX], i_prod[qsm_pkg::P_ZZ], 1'b0);
        n_ent[5] = dbl(i_prod[qsm_pkg::P_YZ], i_prod[qsm_pkg::P_WX], 1'b0);
        n_ent[6] = dbl(i_prod[qsm_pkg::P_XZ], i_prod[qsm_pkg::P_WY], 1'b0);
        n_ent[7] = dbl(i_prod[qsm_pkg::P_YZ], i_prod[qsm_pkg::P_WX], 1'b1);
        n_ent[8] = qsm_pkg::ONE_Q28
                 - dbl(i_prod[qsm_pkg::P_XX], i_prod[qsm_pkg::P_YY], 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ent  <= n_ent;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_ent   = r_ent;
    assign o_side  = r_side;

endmodule

// ----- sv/qsm_scale.sv -----
// stage 3: per-row scale multiply of the rotation entries
// depends on qsm_pkg
module qsm_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [qsm_pkg::SUM_W-1:0]     i_ent [qsm_pkg::N_ENT],
    input  qsm_pkg::t_side                       i_side,
    output logic                                 o_valid,
    output logic signed [qsm_pkg::SCL_W-1:0]     o_scl [qsm_pkg::N_ENT],
    output qsm_pkg::t_trans                      o_trans
);

    logic                             r_valid;
    logic signed [qsm_pkg::Q_W-1:0]   w_row_scale [qsm_pkg::N_ROW];
    logic signed [qsm_pkg::SCL_W-1:0] n_scl [qsm_pkg::N_ENT];
    logic signed [qsm_pkg::SCL_W-1:0] r_scl [qsm_pkg::N_ENT];
    qsm_pkg::t_trans                  r_trans;

    assign w_row_scale[0] = i_side.sx;
    assign w_row_scale[1] = i_side.sy;
    assign w_row_scale[2] = i_side.sz;

    always_comb begin
        for (int r = 0; r < qsm_pkg::N_ROW; r++) begin
            for (int c = 0; c < qsm_pkg::N_ROW; c++) begin
                n_scl[r*qsm_pkg::N_ROW+c] = qsm_pkg::SCL_W'(i_ent[r*qsm_pkg::N_ROW+c])
                                          * qsm_pkg::SCL_W'(w_row_scale[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scl   <= n_scl;
            r_trans <= i_side.trans;
        end
    end

    assign o_valid = r_valid;
    assign o_scl   = r_scl;
    assign o_trans = r_trans;

endmodule

// ----- sv/qsm_sat.sv -----
// stage 4: round to nearest and saturate to q10.14, output register
// depends on qsm_pkg
module qsm_sat (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [qsm_pkg::SCL_W-1:0]     i_scl [qsm_pkg::N_ENT],
    input  qsm_pkg::t_trans                      i_trans,
    output logic                                 o_valid,
    output logic signed [qsm_pkg::ENT_W-1:0]     o_m [qsm_pkg::N_ENT],
    output qsm_pkg::t_trans                      o_trans
);

    logic                             r_valid;
    logic signed [qsm_pkg::SCL_W:0]   w_biased [qsm_pkg::N_ENT];
    logic signed [qsm_pkg::SCL_W:0]   w_shift  [qsm_pkg::N_ENT];
    logic signed [qsm_pkg::ENT_W-1:0] n_m [qsm_pkg::N_ENT];
    logic signed [qsm_pkg::ENT_W-1:0] r_m [qsm_pkg::N_ENT];
    qsm_pkg::t_trans                  r_trans;

    always_comb begin
        for (int k = 0; k < qsm_pkg::N_ENT; k++) begin
            w_biased[k] = (qsm_pkg::SCL_W+1)'(i_scl[k]) + qsm_pkg::RND_BIAS;
            w_shift[k]  = w_biased[k] >>> qsm_pkg::RND_SHIFT;
            if (w_shift[k] > qsm_pkg::SAT_MAX) begin
                n_m[k] = qsm_pkg::ENT_MAX;
            end else if (w_shift[k] < qsm_pkg::SAT_MIN) begin
                n_m[k] = qsm_pkg::ENT_MIN;
            end else begin
                n_m[k] = w_shift[k][qsm_pkg::ENT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= n_m;
            r_trans <= i_trans;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_trans = r_trans;

endmodule

// ----- sv/quaternion_scale_to_matrix_core.sv -----
// quaternion plus per-axis scale to affine matrix, four register stages
// an accepted word passes the product, sum, scale and saturate registers in turn before it is valid at the output
// throughput: one word per cycle while i_ready holds, set by the four-stage pipeline with per-stage stall
// reset: synchronous active-low reset clears the stage valid bits only
// depends on qsm_pkg, qsm_prod, qsm_sum, qsm_scale, qsm_sat
module quaternion_scale_to_matrix_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_quat_x,
    input  logic signed [15:0]            i_quat_y,
    input  logic signed [15:0]            i_quat_z,
    input  logic signed [15:0]            i_quat_w,
    input  logic signed [15:0]            i_scale_x,
    input  logic signed [15:0]            i_scale_y,
    input  logic signed [15:0]            i_scale_z,
    input  logic signed [31:0]            i_trans_x,
    input  logic signed [31:0]            i_trans_y,
    input  logic signed [31:0]            i_trans_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [23:0]            o_m_r0_c0,
    output logic signed [23:0]            o_m_r0_c1,
    output logic signed [23:0]            o_m_r0_c2,
    output logic signed [23:0]            o_m_r1_c0,
    output logic signed [23:0]            o_m_r1_c1,
    output logic signed [23:0]            o_m_r1_c2,
    output logic signed [23:0]            o_m_r2_c0,
    output logic signed [23:0]            o_m_r2_c1,
    output logic signed [23:0]            o_m_r2_c2,
    output logic signed [31:0]            o_out_trans_x,
    output logic signed [31:0]            o_out_trans_y,
    output logic signed [31:0]            o_out_trans_z
);

    qsm_pkg::t_side                    w_side_in;
    logic                              w_en1, w_en2, w_en3, w_en4;
    logic                              w_v1, w_v2, w_v3, w_v4;
    logic signed [qsm_pkg::PROD_W-1:0] w_prod [qsm_pkg::N_PROD];
    qsm_pkg::t_side                    w_side1;
    logic signed [qsm_pkg::SUM_W-1:0]  w_ent [qsm_pkg::N_ENT];
    qsm_pkg::t_side                    w_side2;
    logic signed [qsm_pkg::SCL_W-1:0]  w_scl [qsm_pkg::N_ENT];
    qsm_pkg::t_trans                   w_trans3;
    logic signed [qsm_pkg::ENT_W-1:0]  w_m [qsm_pkg::N_ENT];
    qsm_pkg::t_trans                   w_trans4;

    assign w_side_in.trans.x = i_trans_x;
    assign w_side_in.trans.y = i_trans_y;
    assign w_side_in.trans.z = i_trans_z;
    assign w_side_in.sx      = i_scale_x;
    assign w_side_in.sy      = i_scale_y;
    assign w_side_in.sz      = i_scale_z;

    // a stage loads when it is empty or the next one loads
    assign w_en4   = !w_v4 || i_ready;
    assign w_en3   = !w_v3 || w_en4;
    assign w_en2   = !w_v2 || w_en3;
    assign w_en1   = !w_v1 || w_en2;
    assign o_ready = w_en1;

    qsm_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en1),
        .i_valid  (i_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .i_side   (w_side_in),
        .o_valid  (w_v1),
        .o_prod   (w_prod),
        .o_side   (w_side1)
    );

    qsm_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en2),
        .i_valid (w_v1),
        .i_prod  (w_prod),
        .i_side  (w_side1),
        .o_valid (w_v2),
        .o_ent   (w_ent),
        .o_side  (w_side2)
    );

    qsm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en3),
        .i_valid (w_v2),
        .i_ent   (w_ent),
        .i_side  (w_side2),
        .o_valid (w_v3),
        .o_scl   (w_scl),
        .o_trans (w_trans3)
    );

    qsm_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en4),
        .i_valid (w_v3),
        .i_scl   (w_scl),
        .i_trans (w_trans3),
        .o_valid (w_v4),
        .o_m     (w_m),
        .o_trans (w_trans4)
    );

    assign o_valid       = w_v4;
    assign o_m_r0_c0     = w_m[0];
    assign o_m_r0_c1     = w_m[1];
    assign o_m_r0_c2     = w_m[2];
    assign o_m_r1_c0     = w_m[3];
    assign o_m_r1_c1     = w_m[4];
    assign o_m_r1_c2     = w_m[5];
    assign o_m_r2_c0     = w_m[6];
    assign o_m_r2_c1     = w_m[7];
    assign o_m_r2_c2     = w_m[8];
    assign o_out_trans_x = w_trans4.x;
    assign o_out_trans_y = w_trans4.y;
    assign o_out_trans_z = w_trans4.z;

    // input backpressure only when the whole pipe is full and the output is held
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (w_v1 && w_v2 && w_v3 && o_valid && !i_ready))
        else $error("input stalled while pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> w_v1)
        else $error("accepted word did not enter stage one");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !w_v3) |=> !o_valid)
        else $error("output word appeared from an empty stage");

endmodule
